@@ hw/rtl/tcw_pkg.sv @@
// Shared constants and types for the text console writer.
`timescale 1ns / 1ps

package tcw_pkg;

    // Default screen geometry
    localparam int DEF_COLUMNS = 80;
    localparam int DEF_ROWS    = 25;

    // Fixed field widths of the item ports
    localparam int CMD_W  = 2;
    localparam int CHAR_W = 8;
    localparam int IDX_W  = 11;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_PUT  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SET  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ = 2'd2;

    // Control characters
    localparam logic [CHAR_W-1:0] CR_CODE = 8'h0d;
    localparam logic [CHAR_W-1:0] LF_CODE = 8'h0a;

    // Finished result handed from the sequencer to the output stage
    typedef struct packed {
        logic [IDX_W-1:0]  cursor;
        logic              scrolled;
        logic [CHAR_W-1:0] read_data;
    } tcw_result_t;

endpackage

@@ hw/rtl/tcw_screen_ram.sv @@
// Character store: one write port, one registered read port.
`timescale 1ns / 1ps

module tcw_screen_ram import tcw_pkg::*; #(
    parameter int DEPTH  = DEF_COLUMNS * DEF_ROWS,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [CHAR_W-1:0] wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [CHAR_W-1:0] rdata
);

    logic [CHAR_W-1:0] mem [DEPTH];
    logic [CHAR_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ hw/rtl/tcw_ctrl.sv @@
// Command sequencer: cursor state, position divider, scroll and clear sweeps.
`timescale 1ns / 1ps

module tcw_ctrl import tcw_pkg::*; #(
    parameter int COLUMNS = DEF_COLUMNS,
    parameter int ROWS    = DEF_ROWS,
    parameter int ADDR_W  = $clog2(COLUMNS * ROWS)
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [CMD_W-1:0]  s_command,
    input  logic [CHAR_W-1:0] s_char_code,
    input  logic [IDX_W-1:0]  s_new_position,
    input  logic [IDX_W-1:0]  s_read_address,
    output logic              mem_we,
    output logic [ADDR_W-1:0] mem_waddr,
    output logic [CHAR_W-1:0] mem_wdata,
    output logic [ADDR_W-1:0] mem_raddr,
    input  logic [CHAR_W-1:0] mem_rdata,
    output logic              res_valid,
    input  logic              res_ready,
    output tcw_result_t       res
);

    localparam int CELLS    = COLUMNS * ROWS;
    localparam int LAST     = CELLS - 1;
    localparam int CNT_W    = $clog2(CELLS + 1);
    localparam int ROW_W    = $clog2(ROWS);
    localparam int COL_W    = $clog2(COLUMNS);
    localparam int CMP_W    = (CNT_W > IDX_W) ? CNT_W : IDX_W;
    localparam int DIV_SH   = CNT_W + $clog2(COLUMNS);
    localparam int RCP_W    = CNT_W + 2;
    localparam int PROD_W   = CNT_W + RCP_W;
    localparam logic [RCP_W-1:0] RCP = RCP_W'(((2 ** DIV_SH) + COLUMNS - 1) / COLUMNS);

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_DIV    = 3'd2;
    localparam logic [2:0] ST_RDWAIT = 3'd3;
    localparam logic [2:0] ST_COPY   = 3'd4;
    localparam logic [2:0] ST_ZERO   = 3'd5;
    localparam logic [2:0] ST_DONE   = 3'd6;
    localparam logic [2:0] ST_SPLIT  = 3'd7;

    logic [2:0]        state_reg, state_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [CNT_W-1:0]  rem_reg, rem_next;
    logic [ROW_W-1:0]  quot_reg, quot_next;
    logic              scrolled_reg, scrolled_next;
    logic [CHAR_W-1:0] rdata_reg, rdata_next;

    logic [CNT_W-1:0]  cur_lin;
    logic [CMP_W-1:0]  cur_ext;
    logic [CMP_W-1:0]  newpos_ext;
    logic [CMP_W-1:0]  raddr_ext;
    logic [CMP_W-1:0]  last_ext;
    logic [CNT_W-1:0]  copy_src;
    logic [CNT_W-1:0]  cnt_dec;
    logic [PROD_W-1:0] quot_prod;
    logic [CNT_W-1:0]  col_rem;
    logic              at_last_row;

    assign cur_lin     = CNT_W'(row_reg) * CNT_W'(COLUMNS) + CNT_W'(col_reg);
    assign cur_ext     = CMP_W'(cur_lin);
    assign newpos_ext  = CMP_W'(s_new_position);
    assign raddr_ext   = CMP_W'(s_read_address);
    assign last_ext    = CMP_W'(LAST);
    assign copy_src    = cnt_reg + CNT_W'(COLUMNS);
    assign cnt_dec     = cnt_reg - CNT_W'(1);
    assign quot_prod   = PROD_W'(rem_reg) * PROD_W'(RCP);
    assign col_rem     = rem_reg - CNT_W'(quot_reg) * CNT_W'(COLUMNS);
    assign at_last_row = (row_reg == ROW_W'(ROWS - 1));

    assign res.cursor    = cur_ext[IDX_W-1:0];
    assign res.scrolled  = scrolled_reg;
    assign res.read_data = rdata_reg;

    always_comb begin
        state_next    = state_reg;
        row_next      = row_reg;
        col_next      = col_reg;
        cnt_next      = cnt_reg;
        rem_next      = rem_reg;
        quot_next     = quot_reg;
        scrolled_next = scrolled_reg;
        rdata_next    = rdata_reg;
        s_ready       = 1'b0;
        res_valid     = 1'b0;
        mem_we        = 1'b0;
        mem_waddr     = cur_lin[ADDR_W-1:0];
        mem_wdata     = s_char_code;
        mem_raddr     = raddr_ext[ADDR_W-1:0];

        case (state_reg)
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = cnt_reg[ADDR_W-1:0];
                mem_wdata = '0;
                if (cnt_reg == CNT_W'(LAST)) begin
                    cnt_next   = '0;
                    state_next = ST_IDLE;
                end else begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    scrolled_next = 1'b0;
                    rdata_next    = '0;
                    state_next    = ST_DONE;
                    case (s_command)
                        CMD_PUT: begin
                            if (s_char_code == CR_CODE) begin
                                col_next = '0;
                            end else if (s_char_code == LF_CODE) begin
                                col_next = '0;
                                if (at_last_row) begin
                                    cnt_next      = '0;
                                    scrolled_next = 1'b1;
                                    state_next    = ST_COPY;
                                end else begin
                                    row_next = row_reg + ROW_W'(1);
                                end
                            end else begin
                                mem_we = 1'b1;
                                if (col_reg == COL_W'(COLUMNS - 1)) begin
                                    col_next = '0;
                                    if (at_last_row) begin
                                        cnt_next      = '0;
                                        scrolled_next = 1'b1;
                                        state_next    = ST_COPY;
                                    end else begin
                                        row_next = row_reg + ROW_W'(1);
                                    end
                                end else begin
                                    col_next = col_reg + COL_W'(1);
                                end
                            end
                        end
                        CMD_SET: begin
                            rem_next   = (newpos_ext > last_ext) ? CNT_W'(LAST)
                                                                 : CNT_W'(newpos_ext);
                            state_next = ST_DIV;
                        end
                        CMD_READ: begin
                            if (raddr_ext <= last_ext) begin
                                state_next = ST_RDWAIT;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_DIV: begin
                // row by reciprocal multiplication, exact over the cell range
                quot_next  = ROW_W'(quot_prod >> DIV_SH);
                state_next = ST_SPLIT;
            end
            ST_SPLIT: begin
                row_next   = quot_reg;
                col_next   = COL_W'(col_rem);
                state_next = ST_DONE;
            end
            ST_RDWAIT: begin
                rdata_next = mem_rdata;
                state_next = ST_DONE;
            end
            ST_COPY: begin
                // read one row ahead, write the cell read last cycle
                mem_raddr = copy_src[ADDR_W-1:0];
                mem_waddr = cnt_dec[ADDR_W-1:0];
                mem_wdata = mem_rdata;
                mem_we    = (cnt_reg != '0);
                if (cnt_reg == CNT_W'(CELLS - COLUMNS)) begin
                    state_next = ST_ZERO;
                end else begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            ST_ZERO: begin
                mem_we    = 1'b1;
                mem_waddr = cnt_reg[ADDR_W-1:0];
                mem_wdata = '0;
                if (cnt_reg == CNT_W'(LAST)) begin
                    state_next = ST_DONE;
                end else begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            ST_DONE: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            cnt_reg   <= '0;
            row_reg   <= '0;
            col_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg      <= rem_next;
        quot_reg     <= quot_next;
        scrolled_reg <= scrolled_next;
        rdata_reg    <= rdata_next;
    end

endmodule

@@ hw/rtl/text_console_writer.sv @@
// Top level of the text console writer: sequencer, character store, result register.
`timescale 1ns / 1ps

// Channel  Direction  Handshake           Payload
// s_       in         s_valid / s_ready   s_command, s_char_code, s_new_position,
//                                         s_read_address
// m_       out        m_valid / m_ready   m_cursor, m_scrolled, m_read_data
//
// Steps per item, as walked by the sequencer through the single store write port:
//   put, carriage return, line feed without scroll: decoded, then the result;
//   read: a registered store read; set cursor: reciprocal multiply for the row,
//   then the column; any put that scrolls: rows copied up one cell per cycle,
//   then the last row zeroed.
// After reset a clearing pass zeroes the store one cell per cycle, with s_ready low.
// A finished item waits in the result register; the next item is taken meanwhile.

module text_console_writer import tcw_pkg::*; #(
    parameter int COLUMNS = DEF_COLUMNS,
    parameter int ROWS    = DEF_ROWS
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [CMD_W-1:0]  s_command,
    input  logic [CHAR_W-1:0] s_char_code,
    input  logic [IDX_W-1:0]  s_new_position,
    input  logic [IDX_W-1:0]  s_read_address,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [IDX_W-1:0]  m_cursor,
    output logic              m_scrolled,
    output logic [CHAR_W-1:0] m_read_data
);

    localparam int CELLS  = COLUMNS * ROWS;
    localparam int ADDR_W = $clog2(CELLS);

    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [CHAR_W-1:0] mem_wdata;
    logic [ADDR_W-1:0] mem_raddr;
    logic [CHAR_W-1:0] mem_rdata;
    logic              res_valid;
    logic              res_ready;
    tcw_result_t       res;

    logic              m_valid_reg, m_valid_next;
    tcw_result_t       m_res_reg;

    // Sequencer: decodes each item and walks the store for scroll and clear
    tcw_ctrl #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS),
        .ADDR_W  (ADDR_W)
    ) u_ctrl (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_command      (s_command),
        .s_char_code    (s_char_code),
        .s_new_position (s_new_position),
        .s_read_address (s_read_address),
        .mem_we         (mem_we),
        .mem_waddr      (mem_waddr),
        .mem_wdata      (mem_wdata),
        .mem_raddr      (mem_raddr),
        .mem_rdata      (mem_rdata),
        .res_valid      (res_valid),
        .res_ready      (res_ready),
        .res            (res)
    );

    // Character store, one byte per screen cell
    tcw_screen_ram #(
        .DEPTH  (CELLS),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Result register: load when empty or being drained, hold otherwise
    assign res_ready = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (res_valid && res_ready) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            m_res_reg <= res;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_cursor    = m_res_reg.cursor;
    assign m_scrolled  = m_res_reg.scrolled;
    assign m_read_data = m_res_reg.read_data;

endmodule
